// ----- src/mlt_pkg.sv -----
// Shared types and constants of the MAC learning table.
package mlt_pkg;

	localparam int ENTRIES     = 8;
	localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int MAX_RESULTS = 8;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int MAC_W       = 48;
	localparam int TICK_W      = 32;
	localparam int SLOT_W      = 7;
	localparam int BASE_W      = 4;
	localparam int GROUP_BIT   = 40;

	localparam logic [1:0] OP_LEARN  = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_AGE    = 2'd2;

	localparam logic [1:0] KIND_LOOKUP  = 2'd0;
	localparam logic [1:0] KIND_PROGRAM = 2'd1;
	localparam logic [1:0] KIND_CLEAR   = 2'd2;

	localparam logic [1:0] REG_OWN_MAC     = 2'd0;
	localparam logic [1:0] REG_AGE_LIMIT   = 2'd1;
	localparam logic [1:0] REG_SLOT_BASE   = 2'd2;
	localparam logic [1:0] REG_SWITCH_MODE = 2'd3;

	localparam logic [1:0] MASK_FLOOD = 2'b11;
	localparam logic [1:0] MASK_PORT1 = 2'b01;
	localparam logic [1:0] MASK_PORT2 = 2'b10;

	localparam logic [TICK_W-1:0] AGE_LIMIT_RST = 32'd300000;

	typedef struct packed {
		logic [1:0]        operation;
		logic [MAC_W-1:0]  mac;
		logic              ingress_port;
		logic [TICK_W-1:0] now_tick;
	} item_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [SLOT_W-1:0] hw_slot;
		logic [MAC_W-1:0]  slot_mac;
		logic              slot_port;
		logic [1:0]        egress_mask;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [MAC_W-1:0]  mac;
		logic              port;
		logic [TICK_W-1:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic              match;
		logic              stale;
		logic              older;
		logic [TICK_W-1:0] age;
	} cmp_res_t;

endpackage

// ----- src/mlt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mlt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/mlt_cmp.sv -----
// Shared compare unit: key match, tick age, staleness and LRU order for one entry.
module mlt_cmp (
	input  logic                         valid,
	input  mlt_pkg::entry_t              entry,
	input  logic [mlt_pkg::MAC_W-1:0]    key_mac,
	input  logic [mlt_pkg::TICK_W-1:0]   now_tick,
	input  logic [mlt_pkg::TICK_W-1:0]   age_limit,
	input  logic [mlt_pkg::TICK_W-1:0]   lru_age,
	output mlt_pkg::cmp_res_t            res
);

	logic [mlt_pkg::TICK_W-1:0] age;

	// age wraps modulo 2^32
	assign age = now_tick - entry.stamp;

	always_comb begin
		res.match = valid && (entry.mac == key_mac);
		res.stale = valid && (age > age_limit);
		res.older = (age >= lru_age);
		res.age   = age;
	end

endmodule

// ----- src/mac_learning_table.sv -----
// Top level of the MAC learning table: config registers, entry sweep sequencer, results.
//
//  channel   | handshake          | payload        | notes
//  ----------+--------------------+----------------+------------------------------
//  item in   | start, busy        | item (item_t)  | taken when start & !busy
//  result    | result_stb         | result         | one-cycle strobe per word, no stall
//  config    | cfg_we             | cfg_index/data | taken on any cycle cfg_we is high
//
// Learn, lookup and age walk the entry RAM through its one read port: an address
// state and a compare state per entry, then a finish state; a match ends learn
// and lookup early. Filtered items (group, own-MAC learn, endpoint mode, unknown
// code) skip the walk. Reset clears the valid bits at once; no clearing pass.
// Results cannot be held off by the receiver.
module mac_learning_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  mlt_pkg::item_t               item,
	output logic                         result_stb,
	output mlt_pkg::result_t             result,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [mlt_pkg::MAC_W-1:0]    cfg_data
);

	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EVAL, ST_DONE} state_t;

	state_t state_q;

	logic [mlt_pkg::MAC_W-1:0]  own_mac_q;
	logic [mlt_pkg::TICK_W-1:0] age_limit_q;
	logic [mlt_pkg::BASE_W-1:0] slot_base_q;
	logic                       switch_mode_q;

	logic [1:0]                 op_q;
	logic [mlt_pkg::MAC_W-1:0]  mac_q;
	logic                       port_q;
	logic [mlt_pkg::TICK_W-1:0] now_q;

	logic [mlt_pkg::ENTRIES-1:0] valid_q;
	logic [mlt_pkg::IDX_W-1:0]   idx_q;
	logic                        cand_found_q;
	logic [mlt_pkg::IDX_W-1:0]   cand_q;
	logic [mlt_pkg::IDX_W-1:0]   lru_q;
	logic [mlt_pkg::TICK_W-1:0]  lru_age_q;
	logic [1:0]                  mask_q;
	logic [mlt_pkg::CNT_W-1:0]   cnt_q;
	logic                        pend_q;
	logic [mlt_pkg::IDX_W-1:0]   pend_idx_q;

	logic                        stb_q;
	mlt_pkg::result_t            result_q;

	mlt_pkg::entry_t             rd_entry;
	mlt_pkg::entry_t             wr_entry;
	logic                        ram_we;
	logic [mlt_pkg::IDX_W-1:0]   ram_waddr;
	mlt_pkg::cmp_res_t           cmp;

	logic                        accept;
	logic                        filtered;
	logic                        last_idx;
	logic [mlt_pkg::IDX_W-1:0]   fill_idx;

	assign accept   = start && (state_q == ST_IDLE);
	assign filtered = !switch_mode_q || item.mac[mlt_pkg::GROUP_BIT] || (item.mac == own_mac_q);
	assign last_idx = (idx_q == mlt_pkg::IDX_W'(mlt_pkg::ENTRIES - 1));
	assign fill_idx = cand_found_q ? cand_q : lru_q;

	function automatic logic [mlt_pkg::SLOT_W-1:0] hw_slot_of(
		input logic [mlt_pkg::BASE_W-1:0] base,
		input logic [mlt_pkg::IDX_W-1:0]  idx
	);
		return mlt_pkg::SLOT_W'(base) + mlt_pkg::SLOT_W'(idx);
	endfunction

	// entry write: refresh on a learn hit, fill at the end of a learn miss
	always_comb begin
		wr_entry.mac   = mac_q;
		wr_entry.port  = port_q;
		wr_entry.stamp = now_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		if (op_q == mlt_pkg::OP_LEARN) begin
			if (state_q == ST_EVAL && cmp.match) begin
				ram_we = 1'b1;
			end else if (state_q == ST_DONE) begin
				ram_we    = 1'b1;
				ram_waddr = fill_idx;
			end
		end
	end

	mlt_ram #(
		.WIDTH (mlt_pkg::ENTRY_W),
		.DEPTH (mlt_pkg::ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.raddr (idx_q),
		.rdata (rd_entry)
	);

	mlt_cmp u_cmp (
		.valid     (valid_q[idx_q]),
		.entry     (rd_entry),
		.key_mac   (mac_q),
		.now_tick  (now_q),
		.age_limit (age_limit_q),
		.lru_age   (lru_age_q),
		.res       (cmp)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q     <= '0;
			age_limit_q   <= mlt_pkg::AGE_LIMIT_RST;
			slot_base_q   <= '0;
			switch_mode_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				mlt_pkg::REG_OWN_MAC:     own_mac_q     <= cfg_data;
				mlt_pkg::REG_AGE_LIMIT:   age_limit_q   <= cfg_data[mlt_pkg::TICK_W-1:0];
				mlt_pkg::REG_SLOT_BASE:   slot_base_q   <= cfg_data[mlt_pkg::BASE_W-1:0];
				mlt_pkg::REG_SWITCH_MODE: switch_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= mlt_pkg::OP_LEARN;
			mac_q        <= '0;
			port_q       <= 1'b0;
			now_q        <= '0;
			valid_q      <= '0;
			idx_q        <= '0;
			cand_found_q <= 1'b0;
			cand_q       <= '0;
			lru_q        <= '0;
			lru_age_q    <= '0;
			mask_q       <= mlt_pkg::MASK_FLOOD;
			cnt_q        <= '0;
			pend_q       <= 1'b0;
			pend_idx_q   <= '0;
			stb_q        <= 1'b0;
			result_q     <= '0;
		end else begin
			stb_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q         <= item.operation;
						mac_q        <= item.mac;
						port_q       <= item.ingress_port;
						now_q        <= item.now_tick;
						idx_q        <= '0;
						cand_found_q <= 1'b0;
						cand_q       <= '0;
						lru_q        <= '0;
						lru_age_q    <= '0;
						mask_q       <= mlt_pkg::MASK_FLOOD;
						cnt_q        <= '0;
						pend_q       <= 1'b0;
						case (item.operation)
							mlt_pkg::OP_LEARN: begin
								if (!filtered) begin
									state_q <= ST_READ;
								end
							end
							mlt_pkg::OP_LOOKUP: begin
								if (!switch_mode_q) begin
									mask_q  <= mlt_pkg::MASK_PORT1;
									state_q <= ST_DONE;
								end else if (item.mac[mlt_pkg::GROUP_BIT]) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_READ;
								end
							end
							mlt_pkg::OP_AGE: begin
								if (switch_mode_q) begin
									state_q <= ST_READ;
								end
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= last_idx ? ST_DONE : ST_READ;
					idx_q   <= idx_q + mlt_pkg::IDX_W'(1);
					case (op_q)
						mlt_pkg::OP_LEARN: begin
							if (cmp.match) begin
								// known node: stamp refreshed by the RAM write
								state_q <= ST_IDLE;
								if (rd_entry.port != port_q) begin
									stb_q                <= 1'b1;
									result_q.kind        <= mlt_pkg::KIND_PROGRAM;
									result_q.hw_slot     <= hw_slot_of(slot_base_q, idx_q);
									result_q.slot_mac    <= mac_q;
									result_q.slot_port   <= port_q;
									result_q.egress_mask <= 2'b00;
									result_q.last        <= 1'b1;
								end
							end else if (!cand_found_q) begin
								if (!valid_q[idx_q] || cmp.stale) begin
									cand_found_q <= 1'b1;
									cand_q       <= idx_q;
								end else if (cmp.older) begin
									lru_age_q <= cmp.age;
									lru_q     <= idx_q;
								end
							end
						end
						mlt_pkg::OP_LOOKUP: begin
							if (cmp.match) begin
								mask_q  <= rd_entry.port ? mlt_pkg::MASK_PORT2 : mlt_pkg::MASK_PORT1;
								state_q <= ST_DONE;
							end
						end
						mlt_pkg::OP_AGE: begin
							if (cmp.stale && cnt_q < mlt_pkg::CNT_W'(mlt_pkg::MAX_RESULTS)) begin
								valid_q[idx_q] <= 1'b0;
								cnt_q          <= cnt_q + mlt_pkg::CNT_W'(1);
								pend_q         <= 1'b1;
								pend_idx_q     <= idx_q;
								// a later stale entry makes the held clear not the last word
								if (pend_q) begin
									stb_q                <= 1'b1;
									result_q.kind        <= mlt_pkg::KIND_CLEAR;
									result_q.hw_slot     <= hw_slot_of(slot_base_q, pend_idx_q);
									result_q.slot_mac    <= '0;
									result_q.slot_port   <= 1'b0;
									result_q.egress_mask <= 2'b00;
									result_q.last        <= 1'b0;
								end
							end
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
					case (op_q)
						mlt_pkg::OP_LEARN: begin
							valid_q[fill_idx]    <= 1'b1;
							stb_q                <= 1'b1;
							result_q.kind        <= mlt_pkg::KIND_PROGRAM;
							result_q.hw_slot     <= hw_slot_of(slot_base_q, fill_idx);
							result_q.slot_mac    <= mac_q;
							result_q.slot_port   <= port_q;
							result_q.egress_mask <= 2'b00;
							result_q.last        <= 1'b1;
						end
						mlt_pkg::OP_LOOKUP: begin
							stb_q                <= 1'b1;
							result_q.kind        <= mlt_pkg::KIND_LOOKUP;
							result_q.hw_slot     <= '0;
							result_q.slot_mac    <= '0;
							result_q.slot_port   <= 1'b0;
							result_q.egress_mask <= mask_q;
							result_q.last        <= 1'b1;
						end
						mlt_pkg::OP_AGE: begin
							if (pend_q) begin
								stb_q                <= 1'b1;
								result_q.kind        <= mlt_pkg::KIND_CLEAR;
								result_q.hw_slot     <= hw_slot_of(slot_base_q, pend_idx_q);
								result_q.slot_mac    <= '0;
								result_q.slot_port   <= 1'b0;
								result_q.egress_mask <= 2'b00;
								result_q.last        <= 1'b1;
							end
						end
						default: ;
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign result_stb = stb_q;
	assign result     = result_q;

endmodule
